[hw/rtl/pfv_pkg.sv]
// ----------------------------------------------------------------------------
// pfv_pkg
// Shared types, constants and arithmetic helpers of the path follower.
// ----------------------------------------------------------------------------
`default_nettype none
package pfv_pkg;

  localparam int PLAN_DEPTH_DEF   = 256;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic [13:0] MAX_LIN_RST   = 14'd1065;
  localparam logic [13:0] MAX_ANG_RST   = 14'd4096;
  localparam logic [15:0] LOOKAHEAD_RST = 16'd1434;

  localparam logic [49:0] NEAR_SQ       = 50'd376996;
  localparam logic signed [17:0] NEAR_Q12   = 18'sd614;
  localparam logic [24:0] MIN_LIN_Q12   = 25'd205;
  localparam logic signed [17:0] STOP_ERR_Q12 = 18'sd3277;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam logic signed [20:0] PI_Q16     = 21'sd205887;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_POSE   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MAX_LIN   = 2'd0,
    CFG_MAX_ANG   = 2'd1,
    CFG_LOOKAHEAD = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_DIFF, S_SQ, S_SUM, S_CINIT, S_CORDIC, S_SQRT, S_OUT
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [14:0] heading;
  } req_t;

  typedef struct packed {
    logic [13:0] max_lin;
    logic [13:0] max_ang;
    logic [15:0] lookahead;
  } cfg_t;

  function automatic logic signed [20:0] atan_q16(input logic [4:0] i);
    logic signed [20:0] a;
    begin
      case (i)
        5'd0:  a = 21'sd51472;
        5'd1:  a = 21'sd30385;
        5'd2:  a = 21'sd16055;
        5'd3:  a = 21'sd8150;
        5'd4:  a = 21'sd4091;
        5'd5:  a = 21'sd2047;
        5'd6:  a = 21'sd1024;
        5'd7:  a = 21'sd512;
        5'd8:  a = 21'sd256;
        5'd9:  a = 21'sd128;
        5'd10: a = 21'sd64;
        5'd11: a = 21'sd32;
        5'd12: a = 21'sd16;
        5'd13: a = 21'sd8;
        5'd14: a = 21'sd4;
        5'd15: a = 21'sd2;
        5'd16: a = 21'sd1;
        default: a = 21'sd0;
      endcase
      return a;
    end
  endfunction

  // wrap into [-pi, pi] with at most two steps each way
  function automatic logic signed [17:0] wrap_angle(input logic signed [17:0] a);
    logic signed [17:0] r;
    begin
      r = a;
      if (r > PI_Q12) r = r - TWO_PI_Q12;
      if (r > PI_Q12) r = r - TWO_PI_Q12;
      if (r < -PI_Q12) r = r + TWO_PI_Q12;
      if (r < -PI_Q12) r = r + TWO_PI_Q12;
      return r;
    end
  endfunction

  function automatic logic signed [14:0] clamp_sym(input logic signed [18:0] v,
                                                   input logic [13:0] lim);
    logic signed [18:0] l;
    logic signed [18:0] r;
    begin
      l = signed'({5'd0, lim});
      r = v;
      if (v > l) r = l;
      if (v < -l) r = -l;
      return r[14:0];
    end
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pfv_ram.sv]
// ----------------------------------------------------------------------------
// pfv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pfv_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/pfv_front.sv]
// ----------------------------------------------------------------------------
// pfv_front
// Accepts requests, drops the unused mode and queues the rest (two entries).
// ----------------------------------------------------------------------------
`default_nettype none
module pfv_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output      logic          busy,
  input  wire pfv_pkg::req_t req_in,
  output      logic          q_valid,
  output      pfv_pkg::req_t q_req,
  input  wire logic          q_pop
);
  import pfv_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign busy    = (count_r == 2'd2);
  assign push    = start && !busy && (req_in.mode != MODE_NONE);
  assign q_valid = (count_r != 2'd0);
  assign q_req   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= req_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/pfv_back.sv]
// ----------------------------------------------------------------------------
// pfv_back
// Executes queued requests: plan updates, goal check, nearest-point scan,
// CORDIC bearing, bit-serial square root and command clamping.
// ----------------------------------------------------------------------------
`default_nettype none
module pfv_back #(
  parameter int PLAN_DEPTH   = pfv_pkg::PLAN_DEPTH_DEF,
  parameter int CORDIC_STEPS = pfv_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pfv_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire pfv_pkg::req_t      q_req,
  output      logic               q_pop,
  output      logic               out_valid,
  output      logic [13:0]        out_linear_cmd,
  output      logic signed [14:0] out_angular_cmd,
  output      logic               out_goal_reached
);
  import pfv_pkg::*;

  localparam int AW = (PLAN_DEPTH > 1) ? $clog2(PLAN_DEPTH) : 1;
  localparam int LW = $clog2(PLAN_DEPTH + 1);
  localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  state_t state_r, state_nxt;

  req_t               cur_r, cur_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic signed [14:0] goal_r, goal_nxt;
  logic               reached_r, reached_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic               scan_r, scan_nxt;
  logic signed [24:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [49:0]        sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [49:0]        gd2_r, gd2_nxt, best_r, best_nxt;
  logic signed [24:0] bdx_r, bdx_nxt, bdy_r, bdy_nxt;
  logic signed [27:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [20:0] cz_r, cz_nxt;
  logic               zero_r, zero_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [49:0]        rem_r, rem_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [17:0] err_r, err_nxt;
  logic               ov_r, ov_nxt;
  logic [13:0]        lin_r, lin_nxt;
  logic signed [14:0] ang_r, ang_nxt;

  // memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [47:0]   ram_wdata, ram_rdata;
  logic [LW-1:0] last_len;
  logic [AW-1:0] last_idx;

  assign last_len = len_r - LW'(1);
  assign last_idx = last_len[AW-1:0];

  pfv_ram #(.WIDTH(48), .DEPTH(PLAN_DEPTH)) u_plan_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = ov_r;
  assign out_linear_cmd   = lin_r;
  assign out_angular_cmd  = ang_r;
  assign out_goal_reached = reached_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      len_r     <= '0;
      goal_r    <= '0;
      reached_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      goal_r    <= goal_nxt;
      reached_r <= reached_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;   idx_r  <= idx_nxt;   scan_r <= scan_nxt;
    dx_r   <= dx_nxt;    dy_r   <= dy_nxt;
    sqx_r  <= sqx_nxt;   sqy_r  <= sqy_nxt;
    gd2_r  <= gd2_nxt;   best_r <= best_nxt;
    bdx_r  <= bdx_nxt;   bdy_r  <= bdy_nxt;
    cx_r   <= cx_nxt;    cy_r   <= cy_nxt;   cz_r <= cz_nxt;
    zero_r <= zero_nxt;  step_r <= step_nxt;
    rem_r  <= rem_nxt;   root_r <= root_nxt; bit_r <= bit_nxt;
    cnt_r  <= cnt_nxt;   err_r  <= err_nxt;
    lin_r  <= lin_nxt;   ang_r  <= ang_nxt;
  end

  logic signed [27:0] xs, ys;
  logic [49:0]        d2, trial;
  logic [31:0]        la2;
  logic               done;
  logic signed [17:0] near_e, bear;
  logic [24:0]        half;
  logic [24:0]        max_lin_w;

  always_comb begin
    state_nxt = state_r;
    cur_nxt = cur_r;   len_nxt = len_r;   goal_nxt = goal_r;
    reached_nxt = reached_r;
    idx_nxt = idx_r;   scan_nxt = scan_r;
    dx_nxt = dx_r;     dy_nxt = dy_r;
    sqx_nxt = sqx_r;   sqy_nxt = sqy_r;
    gd2_nxt = gd2_r;   best_nxt = best_r;
    bdx_nxt = bdx_r;   bdy_nxt = bdy_r;
    cx_nxt = cx_r;     cy_nxt = cy_r;     cz_nxt = cz_r;
    zero_nxt = zero_r; step_nxt = step_r;
    rem_nxt = rem_r;   root_nxt = root_r; bit_nxt = bit_r;
    cnt_nxt = cnt_r;   err_nxt = err_r;
    lin_nxt = lin_r;   ang_nxt = ang_r;
    ov_nxt = 1'b0;
    q_pop = 1'b0;
    ram_we = 1'b0;  ram_waddr = len_r[AW-1:0];
    ram_wdata = {q_req.pos_x, q_req.pos_y};
    ram_re = 1'b0;  ram_raddr = idx_r;

    xs = cx_r >>> step_r;
    ys = cy_r >>> step_r;
    d2 = sqx_r + sqy_r;
    la2 = 32'(cfg.lookahead) * 32'(cfg.lookahead);
    done = 1'b0;
    trial = rem_r;
    near_e = '0;
    bear = '0;
    half = '0;
    max_lin_w = {11'd0, cfg.max_lin};

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_req;
          unique case (q_req.mode)
            MODE_CLEAR: begin
              len_nxt     = '0;
              reached_nxt = 1'b1;
            end
            MODE_APPEND: begin
              if (len_r != LW'(PLAN_DEPTH)) begin
                ram_we      = 1'b1;
                len_nxt     = len_r + LW'(1);
                goal_nxt    = q_req.heading;
                reached_nxt = 1'b0;
              end
            end
            MODE_POSE: begin
              if (len_r == '0) begin
                reached_nxt = 1'b1;
                lin_nxt     = '0;
                ang_nxt     = '0;
                ov_nxt      = 1'b1;
              end else begin
                idx_nxt   = last_idx;
                scan_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        dx_nxt    = 25'(signed'(ram_rdata[47:24])) - 25'(cur_r.pos_x);
        dy_nxt    = 25'(signed'(ram_rdata[23:0]))  - 25'(cur_r.pos_y);
        state_nxt = S_SQ;
      end
      S_SQ: begin
        sqx_nxt   = 50'(dx_r) * 50'(dx_r);
        sqy_nxt   = 50'(dy_r) * 50'(dy_r);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        if (!scan_r) begin
          gd2_nxt = d2;
          if (d2 < NEAR_SQ) begin
            near_e = wrap_angle(18'(goal_r) - 18'(cur_r.heading));
            lin_nxt = '0;
            if (near_e < NEAR_Q12 && near_e > -NEAR_Q12) begin
              reached_nxt = 1'b1;
              ang_nxt     = '0;
            end else begin
              ang_nxt = clamp_sym(19'(near_e), cfg.max_ang);
            end
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            scan_nxt  = 1'b1;
            idx_nxt   = '0;
            best_nxt  = '1;
            state_nxt = S_RD;
          end
        end else begin
          if (d2 < best_r) begin
            best_nxt = d2;
            bdx_nxt  = dx_r;
            bdy_nxt  = dy_r;
          end
          // stop at lookahead (never on the first point) or at plan end
          done = (d2 >= {18'd0, la2} && idx_r != '0) || idx_r == last_idx;
          if (done) state_nxt = S_CINIT;
          else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_CINIT: begin
        zero_nxt = (bdx_r == '0) && (bdy_r == '0);
        step_nxt = '0;
        if (bdx_r < 0) begin
          cx_nxt = -28'(bdx_r);
          cy_nxt = -28'(bdy_r);
          cz_nxt = (bdy_r >= 0) ? PI_Q16 : -PI_Q16;
        end else begin
          cx_nxt = 28'(bdx_r);
          cy_nxt = 28'(bdy_r);
          cz_nxt = '0;
        end
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        if (cy_r > 0) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + atan_q16(5'(step_r));
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - atan_q16(5'(step_r));
        end
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(CORDIC_STEPS - 1)) begin
          rem_nxt   = gd2_r;
          root_nxt  = '0;
          bit_nxt   = 50'd1 << 48;
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == 5'd0) begin
          bear    = zero_r ? 18'sd0 : 18'((cz_r + 21'sd8) >>> 4);
          err_nxt = wrap_angle(bear - 18'(cur_r.heading));
        end
        trial = root_r + bit_r;
        if (rem_r >= trial) begin
          rem_nxt  = rem_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd24) state_nxt = S_OUT;
      end
      S_OUT: begin
        half = root_r[25:1];
        if (half < MIN_LIN_Q12) half = MIN_LIN_Q12;
        if (half > max_lin_w) half = max_lin_w;
        lin_nxt = (err_r > STOP_ERR_Q12 || err_r < -STOP_ERR_Q12) ? 14'd0 : half[13:0];
        ang_nxt = clamp_sym({err_r, 1'b0}, cfg.max_ang);
        reached_nxt = 1'b0;
        ov_nxt      = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/path_follow_velocity_command_top.sv]
// ----------------------------------------------------------------------------
// path_follow_velocity_command_top
// Path follower: turns robot poses into linear and angular speed commands.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. Mode
//   clear empties the plan, append stores a point and its heading as goal,
//   pose returns one result; the unused mode is dropped at the input.
//   Requests wait in a two-entry queue; busy is high while it is full.
//   A result appears on out_* for one cycle with out_valid high and must be
//   taken then; there is no stall on the result side.
//   Clear and append are executed in the idle state of the executor; an
//   append is dropped while the plan is full. A pose query on an empty
//   plan is answered from the idle state too. Otherwise the goal check
//   reads, differences, squares and compares the last point; the scan then
//   takes each plan point through memory read, difference, squares and
//   compare, and CORDIC bearing and a bit-serial square root follow.
//   Configuration writes are always ready and take effect in the next cycle.
//   Reset empties the plan and queue and loads the default limits.
// ----------------------------------------------------------------------------
`default_nettype none
module path_follow_velocity_command_top #(
  parameter int PLAN_DEPTH   = pfv_pkg::PLAN_DEPTH_DEF,
  parameter int CORDIC_STEPS = pfv_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [14:0] in_heading,
  output      logic               out_valid,
  output      logic [13:0]        out_linear_cmd,
  output      logic signed [14:0] out_angular_cmd,
  output      logic               out_goal_reached,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import pfv_pkg::*;

  cfg_t cfg_r;
  req_t req_in, q_req;
  logic q_valid, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_lin   <= MAX_LIN_RST;
      cfg_r.max_ang   <= MAX_ANG_RST;
      cfg_r.lookahead <= LOOKAHEAD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_LIN:   cfg_r.max_lin   <= cfg_data[13:0];
        CFG_MAX_ANG:   cfg_r.max_ang   <= cfg_data[13:0];
        CFG_LOOKAHEAD: cfg_r.lookahead <= cfg_data;
        default: ;
      endcase
    end
  end

  assign req_in.mode    = mode_t'(in_mode);
  assign req_in.pos_x   = in_pos_x;
  assign req_in.pos_y   = in_pos_y;
  assign req_in.heading = in_heading;

  pfv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .req_in  (req_in),
    .q_valid (q_valid),
    .q_req   (q_req),
    .q_pop   (q_pop)
  );

  pfv_back #(.PLAN_DEPTH(PLAN_DEPTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_req            (q_req),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_linear_cmd   (out_linear_cmd),
    .out_angular_cmd  (out_angular_cmd),
    .out_goal_reached (out_goal_reached)
  );
endmodule
`default_nettype wire

[hw/rtl/pfv_checker.sv]
// ----------------------------------------------------------------------------
// pfv_checker
// Port-level checks of the path follower, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pfv_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic [1:0]         in_mode,
  input wire logic               out_valid,
  input wire logic [13:0]        out_linear_cmd,
  input wire logic signed [14:0] out_angular_cmd,
  input wire logic               out_goal_reached
);
  a_reached_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_goal_reached |-> out_linear_cmd == 14'd0)
    else $error("goal reached with nonzero linear command");

  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angular_cmd != -15'sd16384) else $error("angular out of range");

  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_linear_cmd, out_angular_cmd, out_goal_reached}))
    else $error("result with unknown bits");

  a_req_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown(in_mode)) else $error("request with unknown mode");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind path_follow_velocity_command_top pfv_checker u_pfv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_linear_cmd   (out_linear_cmd),
  .out_angular_cmd  (out_angular_cmd),
  .out_goal_reached (out_goal_reached)
);
`default_nettype wire

[tb/sv/pfv_cmd_checker.sv]
// ----------------------------------------------------------------------------
// pfv_cmd_checker
// Watches the request, result and register channels of the path follower.
// Keeps its own plan, goal heading and limits, predicts the speed command of
// every pose request and compares each result field with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none
module pfv_cmd_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [14:0] in_heading,
  input  wire logic               out_valid,
  input  wire logic [13:0]        out_linear_cmd,
  input  wire logic signed [14:0] out_angular_cmd,
  input  wire logic               out_goal_reached,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      mismatches,
  output int                      cmds_pending,
  output int                      cmds_checked
);
  import pfv_pkg::*;

  localparam longint NEAR     = 614;
  localparam longint MIN_LIN  = 205;
  localparam longint STOP_ERR = 3277;
  localparam longint HALF_TURN = 12868;
  localparam longint FULL_TURN = 25736;
  localparam longint HALF_TURN_Q16 = 205887;
  localparam longint ATAN_TAB [0:16] = '{51472, 30385, 16055, 8150, 4091, 2047,
    1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct packed {
    logic [13:0]        lin;
    logic signed [14:0] ang;
    logic               reached;
  } cmd_t;

  cmd_t cmd_expect_q[$];

  logic signed [23:0] plan_x [PLAN_DEPTH_DEF];
  logic signed [23:0] plan_y [PLAN_DEPTH_DEF];
  int unsigned        plan_len;
  logic signed [14:0] goal_hd;
  logic               reached;
  longint             lim_lin, lim_ang, lookahead;

  function automatic longint unsigned sq_dist(longint dx, longint dy);
    longint unsigned ax, ay;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    return ax * ax + ay * ay;
  endfunction

  function automatic longint wrap_turn(longint a);
    while (a > HALF_TURN) a -= FULL_TURN;
    while (a < -HALF_TURN) a += FULL_TURN;
    return a;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring rotation, angle kept in Q.16 and rounded to Q.12
  function automatic longint bearing_to(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += (i <= 16) ? ATAN_TAB[i] : 0;
      end else begin
        x -= ys; y += xs; z -= (i <= 16) ? ATAN_TAB[i] : 0;
      end
    end
    return (z + 8) >>> 4;
  endfunction

  function automatic longint clamp_lim(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic cmd_t predict_pose(longint px, longint py, longint hd);
    cmd_t r;
    longint lin, ang, e, half;
    longint unsigned gd2, d2, best, la2;
    int unsigned last, bi;
    lin = 0;
    ang = 0;
    r.reached = reached;
    if (plan_len == 0) begin
      r.reached = 1'b1;
    end else begin
      last = plan_len - 1;
      gd2 = sq_dist(longint'(plan_x[last]) - px, longint'(plan_y[last]) - py);
      if (gd2 < NEAR * NEAR) begin
        e = wrap_turn(longint'(goal_hd) - hd);
        if (e < NEAR && e > -NEAR) r.reached = 1'b1;
        else ang = clamp_lim(e, lim_ang);
      end else begin
        la2 = lookahead * lookahead;
        best = '1;
        bi = last;
        for (int unsigned i = 0; i < plan_len; i++) begin
          d2 = sq_dist(longint'(plan_x[i]) - px, longint'(plan_y[i]) - py);
          if (d2 < best) begin
            best = d2;
            bi = i;
          end
          if (d2 >= la2 && i > 0) break;
        end
        e = wrap_turn(bearing_to(longint'(plan_x[bi]) - px,
                                 longint'(plan_y[bi]) - py) - hd);
        half = longint'(root_floor(gd2) >> 1);
        if (half < MIN_LIN) half = MIN_LIN;
        if (half > lim_lin) half = lim_lin;
        lin = (e > STOP_ERR || e < -STOP_ERR) ? 0 : half;
        ang = clamp_lim(2 * e, lim_ang);
        r.reached = 1'b0;
      end
    end
    r.lin = lin[13:0];
    r.ang = ang[14:0];
    return r;
  endfunction

  assign cmds_pending = cmd_expect_q.size();

  always @(posedge clk) begin : watch
    cmd_t exp_cmd;
    if (!rst_n) begin
      plan_len     <= 0;
      goal_hd      <= '0;
      reached      <= 1'b0;
      lim_lin      <= MAX_LIN_RST;
      lim_ang      <= MAX_ANG_RST;
      lookahead    <= LOOKAHEAD_RST;
      mismatches   <= 0;
      cmds_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAX_LIN:   lim_lin <= cfg_data[13:0];
          CFG_MAX_ANG:   lim_ang <= cfg_data[13:0];
          CFG_LOOKAHEAD: lookahead <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        cmds_checked <= cmds_checked + 1;
        if (cmd_expect_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("%0t: unexpected result lin=%0d ang=%0d reached=%0b", $time,
                     out_linear_cmd, out_angular_cmd, out_goal_reached);
        end else begin
          exp_cmd = cmd_expect_q.pop_front();
          if (exp_cmd.lin !== out_linear_cmd || exp_cmd.ang !== out_angular_cmd ||
              exp_cmd.reached !== out_goal_reached) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("%0t: mismatch exp lin=%0d ang=%0d reached=%0b, got %0d %0d %0b",
                       $time, exp_cmd.lin, exp_cmd.ang, exp_cmd.reached,
                       out_linear_cmd, out_angular_cmd, out_goal_reached);
          end
        end
      end
      if (start && !busy) begin
        case (mode_t'(in_mode))
          MODE_CLEAR: begin
            plan_len <= 0;
            reached  <= 1'b1;
          end
          MODE_APPEND: begin
            // drop points past capacity
            if (plan_len < PLAN_DEPTH_DEF) begin
              plan_x[plan_len] <= in_pos_x;
              plan_y[plan_len] <= in_pos_y;
              plan_len <= plan_len + 1;
              goal_hd  <= in_heading;
              reached  <= 1'b0;
            end
          end
          MODE_POSE: begin
            exp_cmd = predict_pose(in_pos_x, in_pos_y, in_heading);
            reached <= exp_cmd.reached;
            cmd_expect_q.push_back(exp_cmd);
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[tb/sv/path_follow_velocity_command_top_tb.sv]
// ----------------------------------------------------------------------------
// path_follow_velocity_command_top_tb
// Drives plans and pose requests into the path follower under several limit
// settings and sender idle rates; a checker beside the block scores results.
// ----------------------------------------------------------------------------
`default_nettype none
module path_follow_velocity_command_top_tb;
  import pfv_pkg::*;

  localparam int WATCH_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_mode = MODE_NONE;
  logic signed [23:0] in_pos_x = '0;
  logic signed [23:0] in_pos_y = '0;
  logic signed [14:0] in_heading = '0;
  logic               out_valid;
  logic [13:0]        out_linear_cmd;
  logic signed [14:0] out_angular_cmd;
  logic               out_goal_reached;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_MAX_LIN;
  logic [15:0]        cfg_data = '0;

  int mismatches, cmds_pending, cmds_checked;
  int idle_pct = 0;
  int reqs_sent = 0;
  int full_plans = 0;
  int quiet_cycles = 0;
  logic signed [23:0] way_x [$];
  logic signed [23:0] way_y [$];
  logic signed [14:0] last_goal = '0;

  always #5 clk = ~clk;

  path_follow_velocity_command_top uut (.*);

  pfv_cmd_checker chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("path_follow_velocity_command_top_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_req(mode_t m, logic signed [23:0] x, logic signed [23:0] y,
                          logic signed [14:0] h);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    start      <= 1'b1;
    in_mode    <= m;
    in_pos_x   <= x;
    in_pos_y   <= y;
    in_heading <= h;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    reqs_sent++;
    if (m == MODE_CLEAR) begin
      way_x.delete();
      way_y.delete();
    end else if (m == MODE_APPEND && way_x.size() < PLAN_DEPTH_DEF) begin
      way_x.push_back(x);
      way_y.push_back(y);
      last_goal = h;
    end
  endtask

  // drain results, then give the executor time to finish silent requests
  task automatic settle();
    start <= 1'b0;
    forever begin
      @(posedge clk);
      if (cmds_pending == 0) break;
    end
    repeat (20) @(posedge clk);
  endtask

  // hold valid between back-to-back writes; the caller drops it
  task automatic write_cfg(cfg_idx_t idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
  endtask

  function automatic logic signed [23:0] near_coord(logic signed [23:0] c, int span);
    return 24'(c + ($urandom_range(2 * span) - span));
  endfunction

  task automatic random_pose();
    logic signed [23:0] x, y;
    logic signed [14:0] h;
    int k, span;
    x = 24'($urandom);
    y = 24'($urandom);
    if (way_x.size() > 0 && $urandom_range(9) < 8) begin
      k = ($urandom_range(1) == 0) ? way_x.size() - 1 : $urandom_range(way_x.size() - 1);
      case ($urandom_range(2))
        0: span = 400;
        1: span = 3000;
        default: span = 15000;
      endcase
      x = near_coord(way_x[k], span);
      y = near_coord(way_y[k], span);
    end
    case ($urandom_range(3))
      0: h = 15'($urandom);
      1: h = 15'(last_goal + ($urandom_range(1600) - 800));
      default: h = 15'($urandom_range(25736) - 12868);
    endcase
    send_req(MODE_POSE, x, y, h);
  endtask

  task automatic random_plan();
    logic signed [23:0] x, y;
    int n;
    if ($urandom_range(9) > 0)
      send_req(MODE_CLEAR, 24'($urandom), 24'($urandom), 15'($urandom));
    if ($urandom_range(99) < 2) begin
      n = $urandom_range(262, 256);
      full_plans++;
    end else begin
      n = $urandom_range(8, 1);
    end
    x = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(40000) - 20000);
    y = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(40000) - 20000);
    for (int i = 0; i < n; i++) begin
      send_req(MODE_APPEND, x, y, 15'($urandom_range(25736) - 12868));
      x = near_coord(x, 3000);
      y = near_coord(y, 3000);
    end
  endtask

  task automatic set_limits(logic [13:0] lin, logic [13:0] ang, logic [15:0] la);
    write_cfg(CFG_MAX_LIN, {2'b00, lin});
    write_cfg(CFG_MAX_ANG, {2'b00, ang});
    write_cfg(CFG_LOOKAHEAD, la);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty plan, ignored mode, goal heading, turn in place, extremes
    send_req(MODE_POSE, 24'sh7FFFFF, -24'sh800000, 15'sh3FFF);
    send_req(MODE_NONE, -24'sh1, 24'sh7FFFFF, -15'sh4000);
    send_req(MODE_APPEND, 24'sd0, 24'sd0, 15'sd0);
    send_req(MODE_APPEND, 24'sd40960, 24'sd0, 15'sd12868);
    send_req(MODE_POSE, 24'sd0, 24'sd0, 15'sd0);
    send_req(MODE_POSE, 24'sd40960, 24'sd100, 15'sd0);
    send_req(MODE_POSE, 24'sd40960, 24'sd0, 15'sd12868);
    send_req(MODE_POSE, 24'sd40900, -24'sd300, -15'sd12868);
    send_req(MODE_POSE, -24'sh800000, 24'sh7FFFFF, -15'sh4000);
    send_req(MODE_POSE, 24'sd20000, -24'sd20000, 15'sh3FFF);
    send_req(MODE_APPEND, -24'sh800000, 24'sh7FFFFF, -15'sd12868);
    send_req(MODE_POSE, 24'sh7FFFFF, -24'sh800000, 15'sd0);
    send_req(MODE_CLEAR, 24'sd0, 24'sd0, 15'sd0);
    send_req(MODE_POSE, 24'sd5, 24'sd5, 15'sd5);
    send_req(MODE_APPEND, 24'sd100, 24'sd100, 15'sd300);
    send_req(MODE_POSE, 24'sd100, 24'sd100, 15'sd0);
    send_req(MODE_POSE, -24'sd100, -24'sd100, 15'sd0);

    // random: six phases, each with its own limit setting and one of three idle rates
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: set_limits(14'd1065, 14'd4096, 16'd1434);
        1: set_limits(14'h3FFF, 14'h3FFF, 16'hFFFF);
        2: set_limits(14'd0, 14'd0, 16'd0);
        3: set_limits(14'd205, 14'd1, 16'd4096);
        default: set_limits(14'($urandom), 14'($urandom), 16'($urandom));
      endcase
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 61;
        2: idle_pct = 11;
        default: idle_pct = 61;
      endcase
      while (reqs_sent < 20 + (ph + 1) * 315) begin
        random_plan();
        repeat ($urandom_range(8, 2)) begin
          if ($urandom_range(19) == 0)
            send_req(MODE_NONE, 24'($urandom), 24'($urandom), 15'($urandom));
          else if ($urandom_range(19) == 0) random_plan();
          else random_pose();
        end
      end
    end

    settle();
    repeat (60) @(posedge clk);
    $display("covered %0d requests, %0d results checked, %0d plans filled past capacity",
             reqs_sent, cmds_checked, full_plans);
    $display("six limit settings incl. zero and full scale, idle rates 0/11/61 percent");
    if (mismatches == 0 && cmds_pending == 0) begin
      $display("path_follow_velocity_command_top_tb: PASS");
    end else begin
      $display("path_follow_velocity_command_top_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[path_follow_velocity_command_top.f]
hw/rtl/pfv_pkg.sv
hw/rtl/pfv_ram.sv
hw/rtl/pfv_front.sv
hw/rtl/pfv_back.sv
hw/rtl/path_follow_velocity_command_top.sv
hw/rtl/pfv_checker.sv
tb/sv/pfv_cmd_checker.sv
tb/sv/path_follow_velocity_command_top_tb.sv
